@@ hw/rtl/ttm_pkg.sv @@
// ----------------------------------------------------------------------------
// ttm_pkg
// Shared widths, constants and controller/datapath interface types for the
// task timing monitor.
// ----------------------------------------------------------------------------
package ttm_pkg;

   // field widths
   localparam int TIME_W  = 32;
   localparam int SUM_W   = 64;
   localparam int LIMIT_W = 8;

   // packed result: five 32-bit counters and the alarm flag, padded to bytes
   localparam int RSP_BITS = 5 * TIME_W + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // quotient bits produced by the divider, one per cycle
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [TIME_W-1:0]  ALL_ONES    = '1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

   // item kinds on req_tuser
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // commands from the controller
   typedef struct packed {
      logic accept;    // take the item and update the statistics
      logic div_init;  // load the divider from the sum
      logic div_step;  // one quotient bit
      logic publish;   // move the statistics into the output register
   } ttm_cmd_type;

   // status back to the controller
   typedef struct packed {
      logic need_div;  // last item changed the sum and the run count
      logic div_last;  // the current step yields the final quotient bit
      logic out_free;  // the output register can take a new item
   } ttm_stat_type;

endpackage

@@ hw/rtl/ttm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttm_ctrl
// Sequencer of the task timing monitor: takes an item, runs the mean
// divider when the sum changed and hands the statistics to the output.
// ----------------------------------------------------------------------------
module ttm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ttm_pkg::ttm_stat_type stat,
   output ttm_pkg::ttm_cmd_type  cmd
);
   import ttm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_PUBLISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = stat.need_div ? ST_DIV : ST_PUBLISH;
         end
         ST_DIV: begin
            if (stat.div_last) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   assign req_tready   = (state_ff == ST_IDLE);
   assign cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.div_init = (state_ff == ST_PREP) && stat.need_div;
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.publish  = (state_ff == ST_PUBLISH) && stat.out_free;

endmodule

@@ hw/rtl/ttm_dpath.sv @@
// ----------------------------------------------------------------------------
// ttm_dpath
// Statistics registers, the radix-2 mean divider, the limit register and
// the output register of the task timing monitor.
// ----------------------------------------------------------------------------
module ttm_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  ttm_pkg::ttm_cmd_type         cmd,
   output ttm_pkg::ttm_stat_type        stat,
   input  logic                         req_tuser,
   input  logic [ttm_pkg::TIME_W-1:0]   req_tdata,
   input  logic                         csr_wen,
   input  logic [ttm_pkg::LIMIT_W-1:0]  csr_wdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ttm_pkg::RSP_W-1:0]    rsp_tdata
);
   import ttm_pkg::*;

   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [TIME_W-1:0]    shortest_ff, shortest_in;
   logic [TIME_W-1:0]    longest_ff, longest_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TIME_W-1:0]    runs_ff, runs_in;
   logic [TIME_W-1:0]    avg_ff, avg_in;
   logic [TIME_W-1:0]    tally_ff, tally_in;
   logic                 alarm_ff, alarm_in;
   logic                 busy_ff, busy_in;
   logic                 need_div_ff, need_div_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0]    tally_inc;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;
   logic                 q_bit;
   logic [TIME_W-1:0]    quo_next;

   // saturating overrun count
   assign tally_inc = (tally_ff != ALL_ONES) ? tally_ff + TIME_W'(1) : tally_ff;

   // divider step: shift in the next dividend bit, subtract when it fits
   assign trial    = {rem_ff, quo_ff[TIME_W-1]};
   assign diff     = trial - {1'b0, runs_ff};
   assign q_bit    = (trial >= {1'b0, runs_ff});
   assign quo_next = {quo_ff[TIME_W-2:0], q_bit};

   // statistics update
   always_comb begin
      limit_in    = csr_wen ? csr_wdata : limit_ff;
      shortest_in = shortest_ff;
      longest_in  = longest_ff;
      sum_in      = sum_ff;
      runs_in     = runs_ff;
      tally_in    = tally_ff;
      alarm_in    = alarm_ff;
      busy_in     = busy_ff;
      need_div_in = need_div_ff;
      if (cmd.accept) begin
         need_div_in = 1'b0;
         if (req_tuser == KIND_TICK) begin
            if (busy_ff) begin
               tally_in = tally_inc;
               if (tally_inc > TIME_W'(limit_ff)) begin
                  alarm_in = 1'b1;
               end
            end
            busy_in = 1'b1;
         end else begin
            if (req_tdata < shortest_ff) begin
               shortest_in = req_tdata;
            end
            if (req_tdata > longest_ff) begin
               longest_in = req_tdata;
            end
            if (runs_ff != ALL_ONES) begin
               runs_in     = runs_ff + TIME_W'(1);
               sum_in      = sum_ff + SUM_W'(req_tdata);
               need_div_in = 1'b1;
            end
            busy_in = 1'b0;
         end
      end
   end

   // mean divider, one quotient bit a cycle
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      avg_in = avg_ff;
      if (cmd.div_init) begin
         rem_in = sum_ff[SUM_W-1:TIME_W];
         quo_in = sum_ff[TIME_W-1:0];
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = q_bit ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         quo_in = quo_next;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (stat.div_last) begin
            avg_in = quo_next;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({alarm_ff, tally_ff, runs_ff, avg_ff,
                                longest_ff, shortest_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         shortest_ff  <= ALL_ONES;
         longest_ff   <= '0;
         sum_ff       <= '0;
         runs_ff      <= '0;
         avg_ff       <= '0;
         tally_ff     <= '0;
         alarm_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         need_div_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         shortest_ff  <= shortest_in;
         longest_ff   <= longest_in;
         sum_ff       <= sum_in;
         runs_ff      <= runs_in;
         avg_ff       <= avg_in;
         tally_ff     <= tally_in;
         alarm_ff     <= alarm_in;
         busy_ff      <= busy_in;
         need_div_ff  <= need_div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // divider working registers and output payload
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status to the controller
   assign stat.need_div = need_div_ff;
   assign stat.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a result never overwrites one that is still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded while output register is held");

   // partial remainder stays below the divisor during the division
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < runs_ff))
      else $error("divider remainder not below run count");

   // once a run was measured the minimum never exceeds the maximum
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      (runs_ff != '0) |-> (shortest_ff <= longest_ff))
      else $error("minimum above maximum");

   // the alarm is sticky until reset
   a_alarm_sticky: assert property (@(posedge clock) disable iff (reset)
      alarm_ff |=> alarm_ff)
      else $error("overrun alarm cleared without reset");
`endif

endmodule

@@ hw/rtl/task_timing_monitor.sv @@
// Sequence: an accepted item passes ST_PREP, then ST_DIV (the 32-step radix-2 mean divider)
//   only for a done item that updates the mean, then ST_PUBLISH, which loads the output
//   register once it is free. A new item is taken only after the last one is published;
//   an item is taken while the last result waits.
// Reset (synchronous, active high): statistics cleared, minimum all ones,
//   overrun limit 10, no result pending.
// ----------------------------------------------------------------------------
// task_timing_monitor
// Run-time statistics for a periodic task: min, max, mean, run count,
// overrun count and sticky overrun alarm, one result per item.
// ----------------------------------------------------------------------------
module task_timing_monitor (
   input  logic                         clock,
   input  logic                         reset,
   // input items
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ttm_pkg::TIME_W-1:0]   req_tdata,  // [31:0] elapsed
   input  logic                         req_tuser,  // [0] kind
   // result items
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [31:0] min_time, [63:32] max_time, [95:64] mean_time,
   // [127:96] run_total, [159:128] overruns, [160] overrun_alarm, rest zero
   output logic [ttm_pkg::RSP_W-1:0]    rsp_tdata,
   // overrun limit register
   input  logic                         csr_wen,
   input  logic [ttm_pkg::LIMIT_W-1:0]  csr_wdata
);
   import ttm_pkg::*;

   ttm_cmd_type  cmd;
   ttm_stat_type stat;

   // sequencer
   ttm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // statistics and divider
   ttm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ bench/tb_task_timing_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_task_timing_monitor
// Self-checking bench for the task timing monitor. A scoreboard class keeps
// its own copy of the run statistics, predicts the result of every accepted
// item and compares each returned result field by field. Directed items cover
// the min/max extremes, lone done items and the overrun limit boundary; the
// random part mixes well-formed tick/done pairs with stray ticks, tick bursts
// and lone done items across several overrun limit settings, with random
// gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_task_timing_monitor;
   import ttm_pkg::*;

   // one result item as it sits on rsp_tdata, lowest field last
   typedef struct packed {
      logic [RSP_W-5*TIME_W-2:0] pad;
      logic                      alarm;
      logic [TIME_W-1:0]         overruns;
      logic [TIME_W-1:0]         run_total;
      logic [TIME_W-1:0]         mean_time;
      logic [TIME_W-1:0]         max_time;
      logic [TIME_W-1:0]         min_time;
   } stats_type;

   // running statistics and the results still owed by the block
   class stats_tracker;
      logic [TIME_W-1:0]  min_seen;
      logic [TIME_W-1:0]  max_seen;
      logic [SUM_W-1:0]   sum_seen;
      logic [TIME_W-1:0]  runs;
      logic [TIME_W-1:0]  mean;
      logic [TIME_W-1:0]  overrun_cnt;
      logic               alarm_flag;
      logic               busy_flag;
      logic [LIMIT_W-1:0] limit;
      stats_type          stats_due[$];
      int                 errors;
      int                 checked;

      function new();
         min_seen    = ALL_ONES;
         max_seen    = '0;
         sum_seen    = '0;
         runs        = '0;
         mean        = '0;
         overrun_cnt = '0;
         alarm_flag  = 1'b0;
         busy_flag   = 1'b0;
         limit       = LIMIT_RESET;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function int pending();
         return stats_due.size();
      endfunction

      // advance the statistics by one accepted item and queue its result
      function void note_item(logic kind, logic [TIME_W-1:0] elapsed);
         stats_type s;
         if (kind == KIND_TICK) begin
            // tick while the previous run is still going counts as overrun
            if (busy_flag) begin
               if (overrun_cnt != ALL_ONES)
                  overrun_cnt = overrun_cnt + 1'b1;
               if (overrun_cnt > limit)
                  alarm_flag = 1'b1;
            end
            busy_flag = 1'b1;
         end else begin
            if (elapsed < min_seen)
               min_seen = elapsed;
            if (elapsed > max_seen)
               max_seen = elapsed;
            // count, sum and mean freeze once the count is saturated
            if (runs != ALL_ONES) begin
               runs     = runs + 1'b1;
               sum_seen = sum_seen + SUM_W'(elapsed);
               mean     = TIME_W'(sum_seen / SUM_W'(runs));
            end
            busy_flag = 1'b0;
         end
         s.pad       = '0;
         s.alarm     = alarm_flag;
         s.overruns  = overrun_cnt;
         s.run_total = runs;
         s.mean_time = mean;
         s.max_time  = max_seen;
         s.min_time  = min_seen;
         stats_due.push_back(s);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 60)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got 0x%08h want 0x%08h",
                             checked, name, got, want));
      endtask

      task check_result(logic [RSP_W-1:0] data);
         stats_type got;
         stats_type want;
         got = stats_type'(data);
         if (stats_due.size() == 0) begin
            report($sformatf("unexpected result 0x%h", data));
         end else begin
            want = stats_due.pop_front();
            compare_field("min_time", got.min_time, want.min_time);
            compare_field("max_time", got.max_time, want.max_time);
            compare_field("mean_time", got.mean_time, want.mean_time);
            compare_field("run_total", got.run_total, want.run_total);
            compare_field("overruns", got.overruns, want.overruns);
            compare_field("overrun_alarm", TIME_W'(got.alarm), TIME_W'(want.alarm));
            compare_field("padding", TIME_W'(got.pad), TIME_W'(want.pad));
            checked++;
         end
      endtask

      task check_leftover();
         if (stats_due.size() != 0)
            report($sformatf("%0d results never arrived", stats_due.size()));
      endtask
   endclass

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TIME_W-1:0]   req_tdata  = '0;
   logic                req_tuser  = KIND_TICK;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_wen    = 1'b0;
   logic [LIMIT_W-1:0]  csr_wdata  = '0;

   stats_tracker sb = new();
   logic         calm = 1'b0;
   int           stall_left = 0;
   int           items_sent = 0;
   int           limit_writes = 0;

   task_timing_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // note every item the block takes
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_item(req_tuser, req_tdata);
   end

   // result side: check taken items, stall at random
   always @(posedge clock) begin : rsp_side
      int r;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      if (stall_left > 0) begin
         stall_left--;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_tready <= 1'b1;
            stall_left = $urandom_range(0, 8);
         end else if (r < 92) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(20, 60);
         end
      end
   end

   // mostly short gaps, a few long ones, none in a calm stretch
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // elapsed times: near zero, near all ones, full range and typical
   function automatic logic [TIME_W-1:0] pick_elapsed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return TIME_W'($urandom_range(0, 15));
      else if (r < 20)
         return ALL_ONES - TIME_W'($urandom_range(0, 15));
      else if (r < 60)
         return $urandom;
      return TIME_W'($urandom_range(1000, 100000));
   endfunction

   task automatic send_item(input logic kind, input logic [TIME_W-1:0] elapsed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= elapsed;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, pick_elapsed());
   endtask

   // hold the input side until every owed result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // limit writes only with the block idle
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain_results();
      repeat (40) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.set_limit(value);
      limit_writes++;
   endtask

   initial begin : stimulus
      int r;
      int n;
      int count;
      int lim;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: done with no run active, min/max updates, extremes
      send_item(KIND_DONE, 32'd1000);
      send_tick();
      send_item(KIND_DONE, 32'd500);
      send_tick();
      send_item(KIND_DONE, 32'd3000);
      send_tick();
      send_tick();
      send_tick();
      send_item(KIND_DONE, ALL_ONES);
      send_item(KIND_DONE, 32'd0);
      // overrun tally up to exactly the reset limit, alarm must stay low
      repeat (9) send_tick();
      send_item(KIND_DONE, 32'h8000_0000);

      // random phases, each under its own overrun limit
      for (int phase = 1; phase <= 8; phase++) begin
         if (phase == 1) begin
            lim = 255;
         end else if (phase == 8) begin
            lim = 0;
         end else begin
            lim = int'(sb.overrun_cnt) + $urandom_range(0, 30);
            if (lim > 255)
               lim = 255;
         end
         write_limit(LIMIT_W'(lim));
         calm <= ($urandom_range(0, 3) == 0);
         count = 0;
         while (count < 180) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
               send_tick();
               send_item(KIND_DONE, pick_elapsed());
               count += 2;
            end else if (r < 82) begin
               send_tick();
               count++;
            end else if (r < 93) begin
               send_item(KIND_DONE, pick_elapsed());
               count++;
            end else begin
               n = $urandom_range(2, 6);
               repeat (n) send_tick();
               count += n;
            end
            if ($urandom_range(0, 99) < 2)
               drain_results();
         end
      end

      // wind down
      drain_results();
      repeat (40) @(posedge clock);
      sb.check_leftover();
      $display("covered %0d items and %0d results under %0d limit settings",
               items_sent, sb.checked, limit_writes + 1);
      $display("final stats: %0d runs, %0d overruns, alarm %0b",
               sb.runs, sb.overrun_cnt, sb.alarm_flag);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches in total", sb.errors);
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
